### rtl/spq_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes and codes for the sorted priority queue.
// No dependencies; every other file imports this package.
package spq_pkg;

    localparam int DEPTH        = 16;
    localparam int PAYLOAD_BITS = 32;

    localparam int PRIO_W  = 16;
    localparam int DATA_W  = 32;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 2;
    localparam int CAP_W   = 5;
    localparam int CNTO_W  = 5;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // operation codes
    localparam logic [KIND_W-1:0] OP_ENQ   = 2'd0;
    localparam logic [KIND_W-1:0] OP_DEQ   = 2'd1;
    localparam logic [KIND_W-1:0] OP_PEEK  = 2'd2;
    localparam logic [KIND_W-1:0] OP_CLEAR = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic signed [PRIO_W-1:0]       prio;
        logic        [PAYLOAD_BITS-1:0] data;
    } entry_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
    } cell_ctl_t;

    function automatic logic [PAYLOAD_BITS-1:0] pay_in(input logic [DATA_W-1:0] d);
        logic [63:0] w;
        w = 64'(d);
        return w[PAYLOAD_BITS-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] pay_out(input logic [PAYLOAD_BITS-1:0] d);
        logic [63:0] w;
        w = 64'(d);
        return w[DATA_W-1:0];
    endfunction

endpackage

### rtl/spq_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted chain: holds an entry, shifts right on insert,
// left on removal. Depends on spq_pkg.
module spq_cell
    import spq_pkg::*;
(
    input  logic      aclk,
    input  cell_ctl_t ctl,
    input  logic      occ,        // slot holds a live entry
    input  entry_t    new_entry,
    input  logic      left_keep,  // left neighbor stays in place on insert
    input  entry_t    left_entry,
    input  entry_t    right_entry,
    output logic      keep,
    output entry_t    entry
);

    entry_t entry_reg;
    entry_t entry_next;

    // ties stay ahead of the new entry: first come, first served
    assign keep = occ && ($signed(entry_reg.prio) >= $signed(new_entry.prio));

    always_comb begin
        entry_next = entry_reg;
        if (ctl.ins && !keep) begin
            entry_next = left_keep ? new_entry : left_entry;
        end else if (ctl.del) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

### rtl/sorted_priority_queue.sv
`timescale 1ns / 1ps
// Sorted priority queue: a row of DEPTH compare-and-shift cells, head in cell 0.
// The result beat is registered and presented in the cycle after the input beat is accepted.
// Throughput: one operation per cycle; every cell updates in the same cycle, so
// the only limit is the output register draining (s_tready = !m_tvalid || m_tready).
// Reset (aresetn low, synchronous): count 0, capacity 16, no result pending.
// Slot contents are not reset; only slots below the count are ever read.
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data,   // capacity

    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [47:0]      s_tdata,       // [15:0] priority_req, [47:16] payload
    input  logic [1:0]       s_tuser,       // [1:0] kind

    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [55:0]      m_tdata,       // [15:0] head_priority, [47:16] head_payload,
                                            // [52:48] count, [55:53] zero
    output logic [1:0]       m_tuser        // [1:0] status
);

    // ---------------- configuration ----------------
    logic [CAP_W-1:0] cap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    // ---------------- input beat decode ----------------
    logic              s_fire;
    logic [KIND_W-1:0] kind;
    entry_t            new_entry;

    assign s_fire          = s_tvalid && s_tready;
    assign kind            = s_tuser;
    assign new_entry.prio  = s_tdata[PRIO_W-1:0];
    assign new_entry.data  = pay_in(s_tdata[PRIO_W +: DATA_W]);

    // ---------------- occupancy ----------------
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CMP_W-1:0] limit;
    logic             full;
    logic             empty;

    // effective limit is min(capacity, DEPTH)
    assign limit = (CMP_W'(cap_reg) < CMP_W'(DEPTH)) ? CMP_W'(cap_reg) : CMP_W'(DEPTH);
    assign full  = CMP_W'(count_reg) >= limit;
    assign empty = (count_reg == '0);

    cell_ctl_t ctl;
    assign ctl.ins = s_fire && (kind == OP_ENQ) && !full;
    assign ctl.del = s_fire && (kind == OP_DEQ) && !empty;

    always_comb begin
        count_next = count_reg;
        if (s_fire) begin
            unique case (kind)
                OP_ENQ:   if (!full)  count_next = count_reg + CNT_W'(1);
                OP_DEQ:   if (!empty) count_next = count_reg - CNT_W'(1);
                OP_PEEK:  count_next = count_reg;
                OP_CLEAR: count_next = '0;
                default:  count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // ---------------- cell chain ----------------
    entry_t cell_entry [DEPTH];
    logic   cell_keep  [DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_k;

            if (gi == 0) begin : g_first
                assign left_e = new_entry;
                assign left_k = 1'b1;
            end else begin : g_mid
                assign left_e = cell_entry[gi-1];
                assign left_k = cell_keep[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_last
                assign right_e = cell_entry[gi];
            end else begin : g_body
                assign right_e = cell_entry[gi+1];
            end

            spq_cell u_cell (
                .aclk        (aclk),
                .ctl         (ctl),
                .occ         (CNT_W'(gi) < count_reg),
                .new_entry   (new_entry),
                .left_keep   (left_k),
                .left_entry  (left_e),
                .right_entry (right_e),
                .keep        (cell_keep[gi]),
                .entry       (cell_entry[gi])
            );
        end
    endgenerate

    // ---------------- result ----------------
    logic [STAT_W-1:0] status;
    logic [PRIO_W-1:0] head_prio;
    logic [DATA_W-1:0] head_data;
    logic [CMP_W-1:0]  count_wide;

    always_comb begin
        status    = ST_OK;
        head_prio = '0;
        head_data = '0;
        unique case (kind)
            OP_ENQ: begin
                if (full) status = ST_FULL;
            end
            OP_DEQ, OP_PEEK: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    head_prio = cell_entry[0].prio;
                    head_data = pay_out(cell_entry[0].data);
                end
            end
            OP_CLEAR: status = ST_OK;
            default:  status = ST_OK;
        endcase
    end

    assign count_wide = CMP_W'(count_next);

    // output register: takes a new beat whenever it is empty or being drained
    logic        m_tvalid_reg;
    logic [55:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    assign s_tready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_tdata_reg <= {3'b000, count_wide[CNTO_W-1:0], head_data, head_prio};
            m_tuser_reg <= status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(count_reg) <= CMP_W'(DEPTH))
        else $error("entry count above DEPTH");

    a_enq_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (kind == OP_ENQ) && !full) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("accepted enqueue did not grow the count");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (kind == OP_CLEAR)) |=> (count_reg == '0))
        else $error("clear left entries behind");

    a_empty_head_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ST_EMPTY)) |-> (m_tdata[47:0] == '0))
        else $error("empty result carries head data");

endmodule
